### sv/tao_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tao_pkg
// Shared constants, codes and control types of the task order block.
// ----------------------------------------------------------------------------
package tao_pkg;

  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int PRIO_W    = 32;
  localparam int TIME_W    = 48;
  localparam int EFF_W     = 32;
  localparam int ELAP_W    = EFF_W + IDX_W;
  localparam int WSUM_W    = ELAP_W + IDX_W;
  localparam int AVG_W     = 37;

  localparam logic [1:0] STRAT_PRIO  = 2'd0;
  localparam logic [1:0] STRAT_FIFO  = 2'd1;
  localparam logic [1:0] STRAT_LIFO  = 2'd2;
  localparam logic [1:0] STRAT_UNSUP = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_UNSUP    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DIV_GO,
    S_DIV
  } tao_state_t;

  typedef struct packed {
    logic load;
    logic close;
    logic scan_start;
    logic commit;
    logic emit_mid;
    logic emit_last;
    logic emit_err;
    logic div_start;
    logic clear;
  } tao_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic final_pos;
    logic div_done;
  } tao_stat_t;

endpackage

### sv/tao_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tao_div
// Restoring divider, one quotient bit per cycle, for the mean wait.
// ----------------------------------------------------------------------------
module tao_div
  import tao_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WSUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [WSUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(WSUM_W + 1);

  logic [CNT_W:0]    rem;
  logic [WSUM_W-1:0] quo;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              running;
  logic [CNT_W:0]    trial;

  always_comb begin
    trial = {rem[CNT_W-1:0], quo[WSUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(WSUM_W);
        rem     <= '0;
        quo     <= dividend;
        dvs     <= divisor;
      end else if (running) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[WSUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[WSUM_W-2:0], 1'b0};
        end
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### sv/tao_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tao_dp
// Task record stores, selection scan, wait accumulation and result registers.
// ----------------------------------------------------------------------------
module tao_dp
  import tao_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  tao_cmd_t                 cmd,
  input  logic [1:0]               strat,
  input  logic signed [PRIO_W-1:0] priority_score,
  input  logic [TIME_W-1:0]        created_time,
  input  logic [EFF_W-1:0]         effort_hours,
  output tao_stat_t                stat,
  output logic                     result_valid,
  output logic [IDX_W-1:0]         task_index,
  output logic                     last_result,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         completed_count,
  output logic [AVG_W-1:0]         average_wait
);

  function automatic logic before_f(
    input logic [1:0]               s,
    input logic signed [PRIO_W-1:0] pa,
    input logic [TIME_W-1:0]        ta,
    input logic [IDX_W-1:0]         ia,
    input logic signed [PRIO_W-1:0] pb,
    input logic [TIME_W-1:0]        tb,
    input logic [IDX_W-1:0]         ib
  );
    logic r;
    if (s == STRAT_PRIO) begin
      if (pa != pb)      r = (pa < pb);
      else if (ta != tb) r = (ta < tb);
      else               r = (ia < ib);
    end else if (s == STRAT_FIFO) begin
      if (ta != tb) r = (ta < tb);
      else          r = (ia < ib);
    end else begin
      if (ta != tb) r = (ta > tb);
      else          r = (ia < ib);
    end
    return r;
  endfunction

  logic signed [PRIO_W-1:0] prio_mem [MAX_TASKS];
  logic [TIME_W-1:0]        time_mem [MAX_TASKS];
  logic [EFF_W-1:0]         eff_mem  [MAX_TASKS];

  logic [CNT_W-1:0] cnt;
  logic             ovf;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] k;
  logic [1:0]       strat_q;

  logic             issuing;
  logic [IDX_W-1:0] scan_j;
  logic             rd_valid;
  logic             cand_last;
  logic [IDX_W-1:0] cand_idx;

  logic signed [PRIO_W-1:0] rd_prio;
  logic [TIME_W-1:0]        rd_time;
  logic [EFF_W-1:0]         rd_eff;

  logic                     best_valid;
  logic [IDX_W-1:0]         best_idx;
  logic signed [PRIO_W-1:0] best_prio;
  logic [TIME_W-1:0]        best_time;
  logic [EFF_W-1:0]         best_eff;

  logic                     have_prev;
  logic [IDX_W-1:0]         prev_idx;
  logic signed [PRIO_W-1:0] prev_prio;
  logic [TIME_W-1:0]        prev_time;

  logic [ELAP_W-1:0] elapsed;
  logic [WSUM_W-1:0] wait_acc;
  logic              scan_done;

  logic              eligible;
  logic              better;
  logic              div_done;
  logic [WSUM_W-1:0] quotient;

  always_ff @(posedge clk) begin
    if (cmd.load && !cnt[CNT_W-1]) begin
      prio_mem[cnt[IDX_W-1:0]] <= priority_score;
      time_mem[cnt[IDX_W-1:0]] <= created_time;
      eff_mem[cnt[IDX_W-1:0]]  <= effort_hours;
    end
    rd_prio <= prio_mem[scan_j];
    rd_time <= time_mem[scan_j];
    rd_eff  <= eff_mem[scan_j];
  end

  always_comb begin
    eligible = !have_prev || before_f(strat_q, prev_prio, prev_time, prev_idx,
                                      rd_prio, rd_time, cand_idx);
    better   = !best_valid || before_f(strat_q, rd_prio, rd_time, cand_idx,
                                       best_prio, best_time, best_idx);
  end

  // Batch bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.clear) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.load) begin
      if (cnt[CNT_W-1]) ovf <= 1'b1;
      else              cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      n        <= cnt[CNT_W-1] ? cnt : cnt + CNT_W'(1);
      strat_q  <= strat;
      k        <= '0;
      elapsed  <= '0;
      wait_acc <= '0;
    end else if (cmd.commit) begin
      k        <= k + CNT_W'(1);
      wait_acc <= wait_acc + WSUM_W'(elapsed);
      elapsed  <= elapsed + ELAP_W'(best_eff);
    end
  end

  // Scan: issue reads, compare one candidate per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      rd_valid  <= 1'b0;
      scan_done <= 1'b0;
      have_prev <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      scan_done <= rd_valid && cand_last;
      rd_valid  <= issuing;
      if (issuing) begin
        cand_idx  <= scan_j;
        cand_last <= ({1'b0, scan_j} + CNT_W'(1)) == n;
        scan_j    <= scan_j + IDX_W'(1);
        if (({1'b0, scan_j} + CNT_W'(1)) == n) issuing <= 1'b0;
      end
      if (rd_valid && eligible && better) begin
        best_valid <= 1'b1;
        best_idx   <= cand_idx;
        best_prio  <= rd_prio;
        best_time  <= rd_time;
        best_eff   <= rd_eff;
      end
      if (cmd.commit) begin
        have_prev <= 1'b1;
        prev_idx  <= best_idx;
        prev_prio <= best_prio;
        prev_time <= best_time;
      end
      if (cmd.close) have_prev <= 1'b0;
      if (cmd.scan_start) begin
        issuing    <= 1'b1;
        scan_j     <= '0;
        best_valid <= 1'b0;
      end
    end
  end

  tao_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (wait_acc),
    .divisor  (n),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    stat.scan_done = scan_done;
    stat.final_pos = (k + CNT_W'(1)) == n;
    stat.div_done  = div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_mid || cmd.emit_last || cmd.emit_err;
    end
    if (cmd.emit_err) begin
      task_index      <= '0;
      last_result     <= 1'b1;
      status          <= STAT_UNSUP;
      completed_count <= '0;
      average_wait    <= '0;
    end else if (cmd.emit_mid) begin
      task_index      <= best_idx;
      last_result     <= 1'b0;
      status          <= ovf ? STAT_OVERFLOW : STAT_OK;
      completed_count <= '0;
      average_wait    <= '0;
    end else if (cmd.emit_last) begin
      task_index      <= prev_idx;
      last_result     <= 1'b1;
      status          <= ovf ? STAT_OVERFLOW : STAT_OK;
      completed_count <= n;
      average_wait    <= quotient[AVG_W-1:0];
    end
  end

endmodule

### sv/tao_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tao_ctrl
// Sequencer: load, per-position scans, final division and result strobes.
// ----------------------------------------------------------------------------
module tao_ctrl
  import tao_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       last_task,
  input  logic [1:0] strat,
  input  tao_stat_t  stat,
  output tao_cmd_t   cmd,
  output logic       busy
);

  tao_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept && last_task && strat != STRAT_UNSUP) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done && stat.final_pos) state_next = S_DIV_GO;
      end
      S_DIV_GO: state_next = S_DIV;
      S_DIV: begin
        if (stat.div_done) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_LOAD: begin
        busy     = 1'b0;
        cmd.load = accept;
        if (accept && last_task) begin
          if (strat == STRAT_UNSUP) begin
            cmd.emit_err = 1'b1;
            cmd.clear    = 1'b1;
          end else begin
            cmd.close      = 1'b1;
            cmd.scan_start = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.commit = 1'b1;
          if (!stat.final_pos) begin
            cmd.emit_mid   = 1'b1;
            cmd.scan_start = 1'b1;
          end
        end
      end
      S_DIV_GO: cmd.div_start = 1'b1;
      S_DIV: begin
        if (stat.div_done) begin
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

### sv/task_order_and_average_wait.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_order_and_average_wait
// Loads a batch of tasks, streams their order by strategy, reports mean wait.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// request   start / busy            priority_score, created_time, effort_hours,
//                                   last_task
// result    result_valid (1 cycle)  task_index, last_result, status,
//                                   completed_count, average_wait
// config    APB psel/penable/pwrite order_strategy at address 0
//
// A non-closing request stores its task or, past MAX_TASKS, flags overflow. After
// the closing request, each output position costs one full scan of the n stored
// tasks through the record memory read port, and the bit-serial divider runs
// after the last scan, before the final result. Reset is synchronous and needs
// no clearing pass. busy stays high until the final result is out; the receiver
// cannot stall.
// ----------------------------------------------------------------------------
module task_order_and_average_wait
  import tao_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [PRIO_W-1:0] priority_score,
  input  logic [TIME_W-1:0]        created_time,
  input  logic [EFF_W-1:0]         effort_hours,
  input  logic                     last_task,
  output logic                     result_valid,
  output logic [IDX_W-1:0]         task_index,
  output logic                     last_result,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         completed_count,
  output logic [AVG_W-1:0]         average_wait,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [1:0] order_strategy;
  logic       accept;
  tao_cmd_t   cmd;
  tao_stat_t  stat;

  assign pready = 1'b1;
  assign prdata = {30'd0, order_strategy};

  always_ff @(posedge clk) begin
    if (rst) begin
      order_strategy <= STRAT_PRIO;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      order_strategy <= pwdata[1:0];
    end
  end

  assign accept = start && !busy;

  tao_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last_task (last_task),
    .strat     (order_strategy),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  tao_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .strat           (order_strategy),
    .priority_score  (priority_score),
    .created_time    (created_time),
    .effort_hours    (effort_hours),
    .stat            (stat),
    .result_valid    (result_valid),
    .task_index      (task_index),
    .last_result     (last_result),
    .status          (status),
    .completed_count (completed_count),
    .average_wait    (average_wait)
  );

endmodule
